// ----- design/mia_pkg.sv -----
package mia_pkg;

	localparam int WW  = 160;
	localparam int NCH = WW / 32;
	localparam int CW  = $clog2(NCH);
	localparam int DCW = $clog2(WW);

	function automatic logic [1:0] perm_idx(input logic [1:0] k, input logic [2:0] p,
		input logic [1:0] t);
		logic [1:0] v;
		v = t;
		if (k == 2'd2) begin
			v = (p == 3'd0) ? t : ~t & 2'd1;
		end else if (k == 2'd3) begin
			case (p)
				3'd0: v = t;
				3'd1: v = (t == 2'd0) ? 2'd0 : (t == 2'd1) ? 2'd2 : 2'd1;
				3'd2: v = (t == 2'd0) ? 2'd1 : (t == 2'd1) ? 2'd0 : 2'd2;
				3'd3: v = (t == 2'd0) ? 2'd1 : (t == 2'd1) ? 2'd2 : 2'd0;
				3'd4: v = (t == 2'd0) ? 2'd2 : (t == 2'd1) ? 2'd0 : 2'd1;
				3'd5: v = (t == 2'd0) ? 2'd2 : (t == 2'd1) ? 2'd1 : 2'd0;
				default: v = t;
			endcase
		end
		return v;
	endfunction

	function automatic logic perm_odd(input logic [1:0] k, input logic [2:0] p);
		logic o;
		o = 1'b0;
		if (k == 2'd2) begin
			o = (p == 3'd1);
		end else if (k == 2'd3) begin
			o = (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
		end
		return o;
	endfunction

	function automatic logic [2:0] perm_cnt(input logic [1:0] k);
		return (k == 2'd3) ? 3'd6 : (k == 2'd2) ? 3'd2 : 3'd1;
	endfunction

	function automatic logic [WW-1:0] wabs(input logic [WW-1:0] x);
		return x[WW-1] ? -x : x;
	endfunction

endpackage

// ----- design/mia_mul.sv -----
module mia_mul import mia_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [WW-1:0] a,
	input  logic [31:0]   b,
	output logic          done,
	output logic [WW-1:0] prod
);

	logic [WW-1:0] a_q, acc_q;
	logic [31:0]   b_q;
	logic [CW-1:0] k_q;
	logic          busy_q, done_q;
	logic [63:0]   pp;

	// one 32x32 partial product per cycle, most significant chunk first
	assign pp = a_q[WW-1 -: 32] * b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				a_q    <= a;
				b_q    <= b;
				acc_q  <= '0;
				k_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= (acc_q << 32) + WW'(pp);
				a_q   <= a_q << 32;
				k_q   <= k_q + 1'b1;
				if (k_q == CW'(NCH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- design/mia_div.sv -----
module mia_div import mia_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [WW-1:0] num,
	input  logic [WW-1:0] den,
	output logic          done,
	output logic [WW-1:0] quo
);

	logic [WW-1:0]  n_q, d_q, rem_q, q_q;
	logic [DCW-1:0] cnt_q;
	logic           busy_q, done_q;
	logic [WW:0]    trial, diff;
	logic           qb;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, n_q[WW-1]};
	assign diff  = trial - {1'b0, d_q};
	assign qb    = ~diff[WW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				n_q    <= num;
				d_q    <= den;
				rem_q  <= '0;
				q_q    <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= qb ? diff[WW-1:0] : trial[WW-1:0];
				q_q   <= {q_q[WW-2:0], qb};
				n_q   <= n_q << 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCW'(WW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

// ----- design/matrix_inverse_adjugate.sv -----
// matrix inverse by the adjugate, signed fixed point with FRAC_BITS fraction bits
// elem channel: one matrix element per word (row, column, value); the word with
// elem_last set starts the inversion. indices at or beyond DIM are not stored
// inv channel: DIM*DIM words in row-major order with out_last on the final one,
// or a single word with singular and out_last set when the determinant is zero
// elem_ready is high only while loading; loading accepts one word per cycle
// after the last word, each of the DIM*DIM cofactors is built term by term on a
// shared 32x32 multiplier that walks a 160-bit operand in 32-bit chunks, and the
// determinant is then expanded along the first row on the same multiplier
// each entry is then divided by the determinant in a bit-serial divider
// a stalled inv_ready holds the current word and stops all work until it is taken
// reset empties the pipeline; the matrix contents are undefined until written
module matrix_inverse_adjugate import mia_pkg::*; #(
	parameter int DIM       = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        elem_valid,
	output logic        elem_ready,
	input  logic [1:0]  elem_row,
	input  logic [1:0]  elem_col,
	input  logic [31:0] elem_value,
	input  logic        elem_last,
	output logic        inv_valid,
	input  logic        inv_ready,
	output logic [1:0]  inv_row,
	output logic [1:0]  inv_col,
	output logic [31:0] inv_value,
	output logic        singular,
	output logic        out_last
);

	localparam int         IW    = (DIM > 2) ? 2 : 1;
	localparam logic [1:0] KM    = 2'(DIM - 1);
	localparam logic [2:0] NPERM = perm_cnt(KM);
	localparam logic [IW-1:0] LASTI = IW'(DIM - 1);

	typedef enum logic [3:0] {
		S_LOAD, S_TMUL, S_TWAIT, S_DMUL, S_DWAIT, S_DCHK, S_DIV, S_DWT, S_OUT
	} state_t;

	state_t        state_q;
	logic [31:0]   mat_q [DIM][DIM];
	logic [WW-1:0] cof_q [DIM][DIM];
	logic [IW-1:0] r_q, c_q, rd_row, rd_col;
	logic [1:0]    t_q;
	logic [2:0]    p_q;
	logic [WW-1:0] m_q, acc_q, det_q, dmag_q, acc_new, det_new, cof_cur;
	logic          sgn_q, dneg_q, neg_q;
	logic [31:0]   elem, elem_mag, sat;
	logic          mul_go_q, div_go_q, mul_done, div_done;
	logic [WW-1:0] mul_a_q, mul_prod, div_n_q, quo;
	logic [31:0]   mul_b_q;
	logic          high;
	logic [1:0]    ov_row_q, ov_col_q;
	logic [31:0]   ov_val_q;
	logic          ov_valid_q, ov_sing_q, ov_last_q;
	logic          wr_en;

	function automatic logic [IW-1:0] skip(input logic [IW-1:0] rem, input logic [1:0] t);
		logic [2:0] v;
		v = {1'b0, t} + ((t >= 2'(rem)) ? 3'd1 : 3'd0);
		return v[IW-1:0];
	endfunction

	always_comb begin
		if (state_q == S_DMUL) begin
			rd_row = '0;
			rd_col = r_q;
		end else begin
			rd_row = skip(c_q, t_q);
			rd_col = skip(r_q, perm_idx(KM, p_q, t_q));
		end
	end

	assign elem     = mat_q[rd_row][rd_col];
	assign elem_mag = elem[31] ? -elem : elem;
	assign cof_cur  = cof_q[r_q][c_q];
	assign acc_new  = acc_q + ((sgn_q ^ perm_odd(KM, p_q)) ? -mul_prod : mul_prod);
	assign det_new  = det_q + (sgn_q ? -mul_prod : mul_prod);

	assign high = |quo[WW-1:32];
	always_comb begin
		if (!neg_q) begin
			sat = (high || quo[31]) ? 32'h7FFF_FFFF : quo[31:0];
		end else begin
			sat = (high || quo[31:0] > 32'h8000_0000) ? 32'h8000_0000 : -quo[31:0];
		end
	end

	assign wr_en = elem_valid && elem_ready && ({1'b0, elem_row} < 3'(DIM))
		&& ({1'b0, elem_col} < 3'(DIM));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mat_q[elem_row[IW-1:0]][elem_col[IW-1:0]] <= elem_value;
		end
	end

	mia_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	mia_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (div_n_q),
		.den    (dmag_q),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			mul_go_q   <= 1'b0;
			div_go_q   <= 1'b0;
			ov_valid_q <= 1'b0;
			r_q        <= '0;
			c_q        <= '0;
			t_q        <= '0;
			p_q        <= '0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (elem_valid && elem_last) begin
						r_q     <= '0;
						c_q     <= '0;
						t_q     <= '0;
						p_q     <= '0;
						m_q     <= WW'(1);
						sgn_q   <= 1'b0;
						acc_q   <= '0;
						state_q <= S_TMUL;
					end
				end
				S_TMUL: begin
					mul_go_q <= 1'b1;
					mul_a_q  <= m_q;
					mul_b_q  <= elem_mag;
					sgn_q    <= sgn_q ^ elem[31];
					state_q  <= S_TWAIT;
				end
				S_TWAIT: begin
					if (mul_done) begin
						state_q <= S_TMUL;
						if (t_q == KM - 2'd1) begin
							t_q   <= '0;
							m_q   <= WW'(1);
							sgn_q <= 1'b0;
							if (p_q == NPERM - 3'd1) begin
								cof_q[r_q][c_q] <= (r_q[0] ^ c_q[0]) ? -acc_new : acc_new;
								acc_q <= '0;
								p_q   <= '0;
								if (c_q == LASTI) begin
									c_q <= '0;
									if (r_q == LASTI) begin
										r_q     <= '0;
										det_q   <= '0;
										state_q <= S_DMUL;
									end else begin
										r_q <= r_q + 1'b1;
									end
								end else begin
									c_q <= c_q + 1'b1;
								end
							end else begin
								acc_q <= acc_new;
								p_q   <= p_q + 1'b1;
							end
						end else begin
							m_q <= mul_prod;
							t_q <= t_q + 1'b1;
						end
					end
				end
				S_DMUL: begin
					// first row expansion: cofactor of element (0, j) sits at entry (j, 0)
					mul_go_q <= 1'b1;
					mul_a_q  <= wabs(cof_cur);
					mul_b_q  <= elem_mag;
					sgn_q    <= cof_cur[WW-1] ^ elem[31];
					state_q  <= S_DWAIT;
				end
				S_DWAIT: begin
					if (mul_done) begin
						det_q <= det_new;
						if (r_q == LASTI) begin
							r_q     <= '0;
							state_q <= S_DCHK;
						end else begin
							r_q     <= r_q + 1'b1;
							state_q <= S_DMUL;
						end
					end
				end
				S_DCHK: begin
					if (det_q == '0) begin
						ov_row_q   <= '0;
						ov_col_q   <= '0;
						ov_val_q   <= '0;
						ov_sing_q  <= 1'b1;
						ov_last_q  <= 1'b1;
						ov_valid_q <= 1'b1;
						state_q    <= S_OUT;
					end else begin
						dmag_q  <= wabs(det_q);
						dneg_q  <= det_q[WW-1];
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					div_go_q <= 1'b1;
					div_n_q  <= wabs(cof_cur) << (2 * FRAC_BITS);
					neg_q    <= (cof_cur[WW-1] ^ dneg_q) && (cof_cur != '0);
					state_q  <= S_DWT;
				end
				S_DWT: begin
					if (div_done) begin
						ov_row_q   <= 2'(r_q);
						ov_col_q   <= 2'(c_q);
						ov_val_q   <= sat;
						ov_sing_q  <= 1'b0;
						ov_last_q  <= (r_q == LASTI) && (c_q == LASTI);
						ov_valid_q <= 1'b1;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					if (inv_ready) begin
						ov_valid_q <= 1'b0;
						if (ov_last_q) begin
							state_q <= S_LOAD;
						end else begin
							state_q <= S_DIV;
							if (c_q == LASTI) begin
								c_q <= '0;
								r_q <= r_q + 1'b1;
							end else begin
								c_q <= c_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign elem_ready = (state_q == S_LOAD);
	assign inv_valid  = ov_valid_q;
	assign inv_row    = ov_row_q;
	assign inv_col    = ov_col_q;
	assign inv_value  = ov_val_q;
	assign singular   = ov_sing_q;
	assign out_last   = ov_last_q;

endmodule

// ----- design/mia_check.sv -----
module mia_check (
	input logic        clk,
	input logic        arst_n,
	input logic        elem_valid,
	input logic        elem_ready,
	input logic [1:0]  elem_row,
	input logic [1:0]  elem_col,
	input logic [31:0] elem_value,
	input logic        elem_last,
	input logic        inv_valid,
	input logic        inv_ready,
	input logic [1:0]  inv_row,
	input logic [1:0]  inv_col,
	input logic [31:0] inv_value,
	input logic        singular,
	input logic        out_last
);

	// a result word never waits while new elements are taken
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(elem_ready && inv_valid))
		else $error("elem_ready while a result word is pending");

	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		(inv_valid && singular) |-> (out_last && inv_value == 32'd0
			&& inv_row == 2'd0 && inv_col == 2'd0))
		else $error("singular word malformed");

	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		(inv_valid && inv_ready && out_last) |=> elem_ready)
		else $error("not ready for a new matrix after the final word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(inv_valid && !inv_ready) |=> (inv_valid && $stable(inv_value)
			&& $stable(out_last)))
		else $error("stalled result word changed");

	// an offered element word stays put until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(elem_valid && !elem_ready) |=> (elem_valid && $stable(elem_row)
			&& $stable(elem_col) && $stable(elem_value) && $stable(elem_last)))
		else $error("waiting element word changed");

endmodule

bind matrix_inverse_adjugate mia_check u_mia_check (.*);

// ----- dv/matrix_inverse_adjugate_test.sv -----
`timescale 1ns / 100ps

module matrix_inverse_adjugate_test;
	import mia_pkg::*;

	localparam int N = 4;
	localparam int FB = 16;
	localparam int WATCH_LIMIT = 50000;
	localparam int HOLD_CYCLES = 3000;
	localparam int RANDOM_ITEMS = 310;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic [1:0]  row;
		logic [1:0]  col;
		logic [31:0] value;
		logic        sing;
		logic        last;
	} inv_word_t;

	typedef struct {
		logic [1:0]  row;
		logic [1:0]  col;
		logic [31:0] value;
		logic        last;
		logic        typed_sing;
	} elem_word_t;

	logic        clk;
	logic        arst_n;
	logic        elem_valid;
	logic        elem_ready;
	logic [1:0]  elem_row;
	logic [1:0]  elem_col;
	logic [31:0] elem_value;
	logic        elem_last;
	logic        inv_valid;
	logic        inv_ready;
	logic [1:0]  inv_row;
	logic [1:0]  inv_col;
	logic [31:0] inv_value;
	logic        singular;
	logic        out_last;

	logic [31:0] matrix_copy [N][N];
	inv_word_t   inv_expected [$];
	elem_word_t  directed_rows [$];
	int          mismatches;
	int          idle_pct;
	int          stall_pct;
	logic        pressure_on;
	int          hold_cnt;
	int          quiet_cycles;
	int          sent;

	matrix_inverse_adjugate #(.DIM(N), .FRAC_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n),
		.elem_valid(elem_valid), .elem_ready(elem_ready),
		.elem_row(elem_row), .elem_col(elem_col), .elem_value(elem_value),
		.elem_last(elem_last),
		.inv_valid(inv_valid), .inv_ready(inv_ready),
		.inv_row(inv_row), .inv_col(inv_col), .inv_value(inv_value),
		.singular(singular), .out_last(out_last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic wide_t entry(int r, int c);
		wide_t v;
		v = $signed(matrix_copy[r][c]);
		return v;
	endfunction

	// determinant of the 3x3 minor left after dropping one row and one column
	function automatic wide_t minor_det(int skip_r, int skip_c);
		int    rs [3];
		int    cs [3];
		int    nr;
		int    nc;
		wide_t a [3][3];
		nr = 0;
		nc = 0;
		for (int k = 0; k < N; k++) begin
			if (k != skip_r) begin
				rs[nr] = k;
				nr++;
			end
			if (k != skip_c) begin
				cs[nc] = k;
				nc++;
			end
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				a[i][j] = entry(rs[i], cs[j]);
		return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
			- a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
			+ a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
	endfunction

	task automatic predict_inverse();
		wide_t       det;
		wide_t       num;
		logic [255:0] dmag;
		logic [255:0] nmag;
		logic [255:0] quo;
		logic        neg;
		inv_word_t   w;
		det = '0;
		for (int j = 0; j < N; j++) begin
			if (j % 2 == 0)
				det = det + entry(0, j) * minor_det(0, j);
			else
				det = det - entry(0, j) * minor_det(0, j);
		end
		if (det == 0) begin
			w = '{row: 2'd0, col: 2'd0, value: 32'd0, sing: 1'b1, last: 1'b1};
			inv_expected.push_back(w);
			return;
		end
		dmag = (det < 0) ? -det : det;
		for (int r = 0; r < N; r++) begin
			for (int c = 0; c < N; c++) begin
				num = minor_det(c, r);
				if ((r + c) % 2 == 1)
					num = -num;
				neg = ((num < 0) != (det < 0)) && (num != 0);
				nmag = (num < 0) ? -num : num;
				nmag = nmag << (2 * FB);
				quo = nmag / dmag;
				w.row = r[1:0];
				w.col = c[1:0];
				w.sing = 1'b0;
				w.last = (r == N - 1) && (c == N - 1);
				if (!neg)
					w.value = (quo > 256'h7FFFFFFF) ? 32'h7FFFFFFF : quo[31:0];
				else
					w.value = (quo > 256'h80000000) ? 32'h80000000 : -quo[31:0];
				inv_expected.push_back(w);
			end
		end
	endtask

	task automatic send_word(elem_word_t e);
		inv_word_t w;
		if ($urandom_range(0, 99) < idle_pct) begin
			elem_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct)
				@(posedge clk);
		end
		elem_valid <= 1'b1;
		elem_row <= e.row;
		elem_col <= e.col;
		elem_value <= e.value;
		elem_last <= e.last;
		@(posedge clk);
		while (!elem_ready)
			@(posedge clk);
		matrix_copy[e.row][e.col] = e.value;
		sent++;
		if (e.last) begin
			if (e.typed_sing) begin
				w = '{row: 2'd0, col: 2'd0, value: 32'd0, sing: 1'b1, last: 1'b1};
				inv_expected.push_back(w);
			end else begin
				predict_inverse();
			end
		end
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 9 << FB)) - (4 << FB));
			2: return 32'($signed($urandom_range(0, 2047)) - 1024);
			3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	task automatic random_set();
		elem_word_t e;
		int         order [16];
		int         k;
		int         t;
		int         a;
		int         b;
		int         cnt;
		k = $urandom_range(0, 9);
		e.typed_sing = 1'b0;
		if (k < 3) begin
			for (int i = 0; i < 16; i++)
				order[i] = i;
			for (int i = 15; i > 0; i--) begin
				a = $urandom_range(0, i);
				t = order[i];
				order[i] = order[a];
				order[a] = t;
			end
			for (int i = 0; i < 16; i++) begin
				e.row = 2'(order[i] / 4);
				e.col = 2'(order[i] % 4);
				e.value = pick_value();
				e.last = (i == 15);
				send_word(e);
			end
		end else if (k == 3) begin
			// copy one row onto another for a singular matrix
			a = $urandom_range(0, 3);
			b = (a + $urandom_range(1, 3)) % 4;
			for (int j = 0; j < N; j++) begin
				e.row = 2'(b);
				e.col = 2'(j);
				e.value = matrix_copy[a][j];
				e.last = (j == N - 1);
				send_word(e);
			end
		end else begin
			cnt = $urandom_range(1, 4);
			for (int i = 0; i < cnt; i++) begin
				e.row = 2'($urandom_range(0, 3));
				e.col = 2'($urandom_range(0, 3));
				e.value = pick_value();
				e.last = (i == cnt - 1);
				send_word(e);
			end
		end
	endtask

	task automatic add_row(int r, int c, logic [31:0] v, logic l, logic s);
		elem_word_t e;
		e = '{row: r[1:0], col: c[1:0], value: v, last: l, typed_sing: s};
		directed_rows.push_back(e);
	endtask

	always @(posedge clk) begin
		if (pressure_on && hold_cnt < HOLD_CYCLES) begin
			inv_ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else begin
			inv_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		inv_word_t w;
		if ((elem_valid && elem_ready) || (inv_valid && inv_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
		if (arst_n && inv_valid && inv_ready) begin
			if (inv_expected.size() == 0) begin
				$display("%0t: unexpected word row %0d col %0d value %h", $time,
					inv_row, inv_col, inv_value);
				mismatches++;
			end else begin
				w = inv_expected.pop_front();
				if (inv_row !== w.row || inv_col !== w.col || inv_value !== w.value
					|| singular !== w.sing || out_last !== w.last) begin
					$display("%0t: expected r%0d c%0d v%h s%b l%b, got r%0d c%0d v%h s%b l%b",
						$time, w.row, w.col, w.value, w.sing, w.last,
						inv_row, inv_col, inv_value, singular, out_last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		elem_valid = 1'b0;
		elem_row = 2'd0;
		elem_col = 2'd0;
		elem_value = 32'd0;
		elem_last = 1'b0;
		inv_ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		pressure_on = 1'b0;
		hold_cnt = 0;
		quiet_cycles = 0;
		mismatches = 0;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, then a zero on the diagonal, then extreme and tiny entries
		for (int i = 0; i < 16; i++)
			add_row(i / 4, i % 4, (i / 4 == i % 4) ? 32'h00010000 : 32'h0, i == 15, 1'b0);
		add_row(0, 0, 32'h0, 1'b1, 1'b1);
		add_row(0, 0, 32'h7FFFFFFF, 1'b0, 1'b0);
		add_row(1, 1, 32'h80000000, 1'b0, 1'b0);
		add_row(2, 2, 32'h00000001, 1'b1, 1'b0);
		add_row(3, 3, 32'hFFFFFFFF, 1'b1, 1'b0);
		foreach (directed_rows[i])
			send_word(directed_rows[i]);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
					pressure_on <= 1'b1;
				end
				1: begin
					idle_pct = 87;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 87;
				end
				default: begin
					idle_pct = 23;
					stall_pct <= 23;
				end
			endcase
			while (sent < 21 + (ph + 1) * RANDOM_ITEMS / 4)
				random_set();
		end
		elem_valid <= 1'b0;
		while (inv_expected.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
